// ----- rtl/mpq_pkg.sv -----
package mpq_pkg;

  localparam int unsigned DefCapacity = 16;
  localparam int unsigned ValueW      = 32;
  localparam int unsigned CountOutW   = 5;

  typedef enum logic {
    REQ_INSERT = 1'b0,
    REQ_SERVE  = 1'b1
  } req_type_e;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_e;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_e;

endpackage

// ----- rtl/mpq_if.sv -----
interface mpq_req_if import mpq_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                req_type;
  logic [ValueW-1:0]   value;

  modport source (output valid, output req_type, output value, input ready);
  modport sink   (input valid, input req_type, input value, output ready);
endinterface

interface mpq_rsp_if import mpq_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [1:0]           status;
  logic [ValueW-1:0]    served_value;
  logic [CountOutW-1:0] item_count;

  modport source (output valid, output status, output served_value, output item_count,
                  input ready);
  modport sink   (input valid, input status, input served_value, input item_count,
                  output ready);
endinterface

// ----- rtl/min_priority_queue.sv -----
// insert, full insert and empty serve: word in the output register in the cycle after accept
// serve of n entries: one memory read per entry in the scan, then the minimum goes out
// one request in work at a time: an insert every cycle when the response is taken at once
// reset clears the entry count and the control state; the value memory is not cleared
module min_priority_queue import mpq_pkg::*; #(
  parameter int unsigned CAPACITY = DefCapacity
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  mpq_req_if.sink       req_i,
  mpq_rsp_if.source     rsp_o
);

  localparam int unsigned AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNTW = $clog2(CAPACITY + 1);

  logic [ValueW-1:0] mem [CAPACITY];

  state_e            state_q, state_d;
  logic [CNTW-1:0]   count_q, count_d;
  logic [AW-1:0]     scan_q, scan_d;
  logic              more_q, more_d;
  logic              dv_q;
  logic [AW-1:0]     didx_q;
  logic [ValueW-1:0] rdata_q;
  logic [ValueW-1:0] best_val_q, best_val_d;
  logic [AW-1:0]     best_idx_q, best_idx_d;

  logic                 rsp_valid_q, rsp_valid_d;
  status_e              rsp_status_q, rsp_status_d;
  logic [ValueW-1:0]    rsp_value_q, rsp_value_d;
  logic [CountOutW-1:0] rsp_count_q, rsp_count_d;

  logic              in_fire, is_full, is_empty, scan_done, cand_better, rd_en, wr_en;
  logic [AW-1:0]     last_idx, rd_addr, wr_addr;
  logic [ValueW-1:0] wr_data;

  assign req_i.ready  = (state_q == ST_IDLE) && (!rsp_valid_q || rsp_o.ready);
  assign in_fire      = req_i.valid && req_i.ready;
  assign is_full      = (count_q == CNTW'(CAPACITY));
  assign is_empty     = (count_q == '0);
  assign last_idx     = AW'(count_q - CNTW'(1));
  assign scan_done    = (state_q == ST_SCAN) && dv_q && (didx_q == last_idx);
  assign cand_better  = (didx_q == '0) || ($signed(rdata_q) < $signed(best_val_q));

  assign rsp_o.valid        = rsp_valid_q;
  assign rsp_o.status       = rsp_status_q;
  assign rsp_o.served_value = rsp_value_q;
  assign rsp_o.item_count   = rsp_count_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire && (req_i.req_type == REQ_SERVE) && !is_empty) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    count_d      = count_q;
    scan_d       = scan_q;
    more_d       = more_q;
    best_val_d   = best_val_q;
    best_idx_d   = best_idx_q;
    rsp_valid_d  = rsp_valid_q && !rsp_o.ready;
    rsp_status_d = rsp_status_q;
    rsp_value_d  = rsp_value_q;
    rsp_count_d  = rsp_count_q;
    rd_en        = 1'b0;
    rd_addr      = scan_q;
    wr_en        = 1'b0;
    wr_addr      = count_q[AW-1:0];
    wr_data      = req_i.value;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          rsp_valid_d  = 1'b1;
          rsp_value_d  = '0;
          rsp_status_d = STATUS_OK;
          if (req_i.req_type == REQ_INSERT) begin
            if (is_full) begin
              rsp_status_d = STATUS_FULL;
            end else begin
              wr_en   = 1'b1;
              count_d = count_q + CNTW'(1);
            end
            rsp_count_d = CountOutW'(count_d);
          end else if (is_empty) begin
            rsp_status_d = STATUS_EMPTY;
            rsp_count_d  = '0;
          end else begin
            rsp_valid_d = rsp_valid_q && !rsp_o.ready;
            scan_d      = '0;
            more_d      = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        if (more_q) begin
          rd_en = 1'b1;
          if (scan_q == last_idx) begin
            more_d = 1'b0;
          end else begin
            scan_d = scan_q + AW'(1);
          end
        end
        if (dv_q && cand_better) begin
          best_val_d = rdata_q;
          best_idx_d = didx_q;
        end
        // last entry moves into the freed slot
        if (scan_done) begin
          wr_en        = 1'b1;
          wr_addr      = best_idx_d;
          wr_data      = rdata_q;
          count_d      = count_q - CNTW'(1);
          rsp_valid_d  = 1'b1;
          rsp_status_d = STATUS_OK;
          rsp_value_d  = best_val_d;
          rsp_count_d  = CountOutW'(count_d);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      more_q      <= 1'b0;
      dv_q        <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      more_q      <= more_d;
      dv_q        <= rd_en;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    scan_q       <= scan_d;
    didx_q       <= scan_q;
    best_val_q   <= best_val_d;
    best_idx_q   <= best_idx_d;
    rsp_status_q <= rsp_status_d;
    rsp_value_q  <= rsp_value_d;
    rsp_count_q  <= rsp_count_d;
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNTW'(CAPACITY)) else $error("entry count above capacity");

  a_scan_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (count_q != '0)) else $error("scan with no entries");

  a_done_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_done |-> !rsp_valid_q) else $error("serve result would overwrite pending word");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (req_i.req_type == REQ_INSERT) && !is_full)
      |=> (count_q == $past(count_q) + CNTW'(1))) else $error("insert did not grow count");

  a_serve_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_done |=> (count_q == $past(count_q) - CNTW'(1) && state_q == ST_IDLE))
    else $error("serve did not shrink count");
`endif

endmodule
